### src/vbms_pkg.sv
// Shared constants, types and tables for the vehicle bicycle-model step core.
// Used by the controller, the datapath, the CORDIC engine and the cell divider.
// No dependencies.
package vbms_pkg;

    // Number formats of the pose update.
    localparam int ANGLE_BITS    = 16;
    localparam int POS_FRAC_BITS = 8;
    localparam int CORDIC_ITERS  = 16;
    localparam int TURN_SHIFT    = 32 - ANGLE_BITS;
    localparam int ITER_W        = $clog2(CORDIC_ITERS);
    localparam int ROUND_SH      = 47 - POS_FRAC_BITS;
    localparam int PIX_W         = 32 - POS_FRAC_BITS;

    // CORDIC vector and angle widths.
    localparam int CW = 64;
    localparam int ZW = 34;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MAGNITUDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE       = 3'd5;

    // Command codes.
    localparam logic [1:0] THR_NONE       = 2'd0;
    localparam logic [1:0] THR_UP         = 2'd1;
    localparam logic [1:0] THR_DOWN       = 2'd2;
    localparam logic [1:0] THR_UNUSED     = 2'd3;
    localparam logic [1:0] STEER_KEEP     = 2'd0;
    localparam logic [1:0] STEER_LEFT     = 2'd1;
    localparam logic [1:0] STEER_RIGHT    = 2'd2;
    localparam logic [1:0] STEER_STRAIGHT = 2'd3;

    // Reset values.
    localparam logic [10:0] RST_MAX_SPEED  = 11'd600;
    localparam logic [7:0]  RST_FRICTION   = 8'd5;
    localparam logic [7:0]  RST_ACCEL      = 8'd30;
    localparam logic [13:0] RST_STEER_MAG  = 14'd5215;
    localparam logic [9:0]  RST_WHEEL_BASE = 10'd130;
    localparam logic [9:0]  RST_CELL_SIZE  = 10'd130;
    localparam logic [31:0] RST_POSITION   = 32'(780) << POS_FRAC_BITS;
    localparam logic [ANGLE_BITS-1:0] RST_HEADING =
        ANGLE_BITS'((1 << ANGLE_BITS) - (1 << (ANGLE_BITS - 2)));

    localparam logic signed [13:0] SPEED_LIMIT = 14'sd2047;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Quarter and half turn in 2^-32 turn.
    localparam logic signed [ZW-1:0] Z_QUARTER = {{(ZW-32){1'b0}}, 32'h4000_0000};
    localparam logic signed [ZW-1:0] Z_HALF    = {{(ZW-32){1'b0}}, 32'h8000_0000};

    // Arctangent of 2^-i in 2^-32 turn.
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_DISTANCE,
        ST_ROT_H_GO,
        ST_ROT_H_WAIT,
        ST_ROT_F_GO,
        ST_ROT_F_WAIT,
        ST_PREP,
        ST_MUL,
        ST_ADD,
        ST_VEC_GO,
        ST_VEC_WAIT,
        ST_DIV_WAIT,
        ST_DONE
    } ctrl_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic speed;
        logic distance;
        logic rot_h_go;
        logic rot_f_go;
        logic store_h;
        logic store_f;
        logic prep;
        logic mul;
        logic add;
        logic vec_go;
        logic store_heading;
        logic out_load;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic cordic_busy;
        logic div_busy;
    } sts_t;

endpackage

### src/vbms_cordic.sv
// Iterative CORDIC engine, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on vbms_pkg for widths and the arctangent table.
module vbms_cordic (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         vec_mode,
    input  logic signed [vbms_pkg::CW-1:0] x0,
    input  logic signed [vbms_pkg::CW-1:0] y0,
    input  logic signed [vbms_pkg::ZW-1:0] z0,
    output logic signed [vbms_pkg::CW-1:0] x,
    output logic signed [vbms_pkg::CW-1:0] y,
    output logic signed [vbms_pkg::ZW-1:0] z,
    output logic                         busy
);
    import vbms_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next, at;
    logic [ITER_W-1:0]    cnt_reg;
    logic                 busy_reg;
    logic                 vec_reg;
    logic                 sigma;

    // One micro-rotation; the direction comes from z when rotating, from y when vectoring.
    always_comb
    begin
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        at    = $signed(ZW'(atan_turn32(5'(cnt_reg))));
        sigma = vec_reg ? y_reg[CW-1] : ~z_reg[ZW-1];
        if (sigma)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    // Iteration counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= vec_mode;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign busy = busy_reg;

endmodule

### src/vbms_div.sv
// Two-lane restoring divider for the grid column and row, one quotient bit per cycle.
// Depends on vbms_pkg for the position format.
module vbms_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [9:0]  cell_size,
    output logic        busy,
    output logic [23:0] col,
    output logic [23:0] row
);
    import vbms_pkg::*;

    localparam int CNT_W = $clog2(PIX_W);

    logic [PIX_W-1:0] dvd_reg [2];
    logic [9:0]       rem_reg [2];
    logic             neg_reg [2];
    logic [PIX_W-1:0] dvd_next [2];
    logic [9:0]       rem_next [2];
    logic [10:0]      trial [2];
    logic [31:0]      pin [2];
    logic [31:0]      mag [2];
    logic [PIX_W-1:0] quo [2];
    logic [9:0]       cs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    // Shift-subtract step and start values for both lanes.
    always_comb
    begin
        pin[0] = pos_x;
        pin[1] = pos_y;
        for (int l = 0; l < 2; l++)
        begin
            mag[l]   = pin[l][31] ? (~pin[l] + 32'd1) : pin[l];
            trial[l] = {rem_reg[l], dvd_reg[l][PIX_W-1]};
            if (trial[l] >= {1'b0, cs_reg})
            begin
                rem_next[l] = 10'(trial[l] - {1'b0, cs_reg});
                dvd_next[l] = {dvd_reg[l][PIX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial[l][9:0];
                dvd_next[l] = {dvd_reg[l][PIX_W-2:0], 1'b0};
            end
            quo[l] = neg_reg[l] ? (~dvd_reg[l] + 1'b1) : dvd_reg[l];
        end
    end

    // Bit counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PIX_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Dividend, remainder and sign registers; a zero cell size divides by one.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cs_reg <= (cell_size == 10'd0) ? 10'd1 : cell_size;
            for (int l = 0; l < 2; l++)
            begin
                dvd_reg[l] <= mag[l][31:POS_FRAC_BITS];
                rem_reg[l] <= '0;
                neg_reg[l] <= pin[l][31];
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dvd_reg[l] <= dvd_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    assign busy = busy_reg;
    assign col  = 24'(quo[0]);
    assign row  = 24'(quo[1]);

endmodule

### src/vbms_ctrl.sv
// Sequencer for one pose update: issues datapath commands and owns the handshakes.
// Depends on vbms_pkg for the state, command and status types.
module vbms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  vbms_pkg::sts_t sts,
    output vbms_pkg::cmd_t cmd
);
    import vbms_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SPEED;
                end
            end
            ST_SPEED:
            begin
                cmd.speed  = 1'b1;
                state_next = ST_DISTANCE;
            end
            ST_DISTANCE:
            begin
                cmd.distance = 1'b1;
                state_next   = ST_ROT_H_GO;
            end
            ST_ROT_H_GO:
            begin
                cmd.rot_h_go = 1'b1;
                state_next   = ST_ROT_H_WAIT;
            end
            ST_ROT_H_WAIT:
            begin
                if (!sts.cordic_busy)
                begin
                    cmd.store_h = 1'b1;
                    state_next  = ST_ROT_F_GO;
                end
            end
            ST_ROT_F_GO:
            begin
                cmd.rot_f_go = 1'b1;
                state_next   = ST_ROT_F_WAIT;
            end
            ST_ROT_F_WAIT:
            begin
                if (!sts.cordic_busy)
                begin
                    cmd.store_f = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_VEC_GO;
            end
            ST_VEC_GO:
            begin
                cmd.vec_go = 1'b1;
                state_next = ST_VEC_WAIT;
            end
            ST_VEC_WAIT:
            begin
                if (!sts.cordic_busy)
                begin
                    cmd.store_heading = 1'b1;
                    state_next        = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait here only while the previous transaction is still held.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/vbms_datapath.sv
// Datapath of the pose update: registers, speed logic, products, CORDIC and divider.
// Depends on vbms_pkg, vbms_cordic and vbms_div.
module vbms_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vbms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vbms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [15:0]                         dt,
    input  logic [1:0]                          throttle,
    input  logic [1:0]                          steer,
    input  vbms_pkg::cmd_t                      cmd,
    output vbms_pkg::sts_t                      sts,
    output logic signed [31:0]                  pos_x,
    output logic signed [31:0]                  pos_y,
    output logic signed [15:0]                  heading_out,
    output logic signed [11:0]                  speed_out,
    output logic signed [23:0]                  cell_col,
    output logic signed [23:0]                  cell_row
);
    import vbms_pkg::*;

    // Configuration registers.
    logic [10:0] max_speed_reg;
    logic [7:0]  friction_step_reg;
    logic [7:0]  accel_step_reg;
    logic [13:0] steer_magnitude_reg;
    logic [9:0]  wheel_base_reg;
    logic [9:0]  cell_size_reg;

    // Vehicle state.
    logic [31:0]           position_x_reg, position_y_reg;
    logic [ANGLE_BITS-1:0] heading_reg;
    logic signed [11:0]    speed_reg;
    logic signed [15:0]    steer_angle_reg;

    // Captured transaction.
    logic [15:0] dt_reg;
    logic [1:0]  throttle_reg, steer_reg;

    // Working registers.
    logic signed [27:0] d_reg;
    logic               flip_reg;
    logic               zero_reg;
    logic signed [ZW-1:0] ch_reg, sh_reg, cf_reg, sf_reg;
    logic signed [ZW:0]   ax_reg, bx_reg, ay_reg, by_reg;
    logic signed [62:0]   mx_reg, nx_reg, my_reg, ny_reg;
    logic signed [44:0]   wx_reg, wy_reg;
    logic signed [CW-1:0] vx_reg, vy_reg;

    // Output registers.
    logic [31:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] heading_out_reg;
    logic signed [11:0] speed_out_reg;
    logic [23:0]        cell_col_reg, cell_row_reg;

    // Combinational signals.
    logic signed [13:0]   sp_a, sp_b, sp_c, ms, fr, acc;
    logic signed [15:0]   steer_next;
    logic signed [28:0]   d_full;
    logic [ANGLE_BITS-1:0] rot_angle;
    logic signed [ZW-1:0] z_turn, z_fold;
    logic                 flip_next;
    logic                 cordic_start, cordic_vec;
    logic signed [CW-1:0] c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0] c_z0, c_z;
    logic                 cordic_busy;
    logic signed [ZW-1:0] c_cos, c_sin;
    logic signed [CW-1:0] rnd_x, rnd_y;
    logic [31:0]          z_rnd;
    logic                 div_busy;
    logic [23:0]          div_col, div_row;

    localparam logic signed [CW-1:0] RND_HALF = CW'(64'sd1 <<< (ROUND_SH - 1));

    // Speed: throttle, saturation, clamp to max speed, then friction toward zero.
    always_comb
    begin
        acc  = $signed({6'b0, accel_step_reg});
        ms   = $signed({3'b0, max_speed_reg});
        fr   = $signed({6'b0, friction_step_reg});
        sp_a = 14'(speed_reg);
        case (throttle_reg)
            THR_UP:   sp_a = sp_a + acc;
            THR_DOWN: sp_a = sp_a - acc;
            default:  sp_a = sp_a;
        endcase
        sp_b = sp_a;
        if (sp_b > SPEED_LIMIT)
        begin
            sp_b = SPEED_LIMIT;
        end
        if (sp_b < -SPEED_LIMIT)
        begin
            sp_b = -SPEED_LIMIT;
        end
        if (sp_b > ms)
        begin
            sp_b = ms;
        end
        if (sp_b < -ms)
        begin
            sp_b = -ms;
        end
        if (sp_b > 14'sd0)
        begin
            sp_c = sp_b - fr;
            if (sp_c < 14'sd0)
            begin
                sp_c = 14'sd0;
            end
        end
        else
        begin
            sp_c = sp_b + fr;
            if (sp_c > 14'sd0)
            begin
                sp_c = 14'sd0;
            end
        end
    end

    // Steering command.
    always_comb
    begin
        case (steer_reg)
            STEER_LEFT:     steer_next = -$signed({2'b0, steer_magnitude_reg});
            STEER_RIGHT:    steer_next = $signed({2'b0, steer_magnitude_reg});
            STEER_STRAIGHT: steer_next = 16'sd0;
            default:        steer_next = steer_angle_reg;
        endcase
    end

    assign d_full = speed_reg * $signed({1'b0, dt_reg});

    // Angle folding into the right half plane before a rotation pass.
    always_comb
    begin
        rot_angle = cmd.rot_f_go ? ANGLE_BITS'(heading_reg + steer_angle_reg[ANGLE_BITS-1:0])
                                 : heading_reg;
        z_turn    = ZW'($signed({rot_angle, {TURN_SHIFT{1'b0}}}));
        flip_next = 1'b0;
        z_fold    = z_turn;
        if (z_turn > Z_QUARTER)
        begin
            z_fold    = z_turn - Z_HALF;
            flip_next = 1'b1;
        end
        else if (z_turn < -Z_QUARTER)
        begin
            z_fold    = z_turn + Z_HALF;
            flip_next = 1'b1;
        end
    end

    // CORDIC start values: unit vector for rotation, heading vector for vectoring.
    always_comb
    begin
        cordic_start = cmd.rot_h_go || cmd.rot_f_go || cmd.vec_go;
        cordic_vec   = cmd.vec_go;
        if (cmd.vec_go)
        begin
            c_x0 = vx_reg[CW-1] ? -vx_reg : vx_reg;
            c_y0 = vx_reg[CW-1] ? -vy_reg : vy_reg;
            c_z0 = vx_reg[CW-1] ? Z_HALF : '0;
        end
        else
        begin
            c_x0 = CW'(CORDIC_GAIN);
            c_y0 = '0;
            c_z0 = z_fold;
        end
    end

    vbms_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cordic_start),
        .vec_mode (cordic_vec),
        .x0       (c_x0),
        .y0       (c_y0),
        .z0       (c_z0),
        .x        (c_x),
        .y        (c_y),
        .z        (c_z),
        .busy     (cordic_busy)
    );

    assign c_cos = flip_reg ? -ZW'(c_x) : ZW'(c_x);
    assign c_sin = flip_reg ? -ZW'(c_y) : ZW'(c_y);

    // Rounded position steps and heading rounding.
    assign rnd_x = (CW'(mx_reg) + RND_HALF) >>> ROUND_SH;
    assign rnd_y = (CW'(my_reg) + RND_HALF) >>> ROUND_SH;
    assign z_rnd = c_z[31:0] + 32'(1 << (TURN_SHIFT - 1));

    vbms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.vec_go),
        .pos_x     (position_x_reg),
        .pos_y     (position_y_reg),
        .cell_size (cell_size_reg),
        .busy      (div_busy),
        .col       (div_col),
        .row       (div_row)
    );

    assign sts.cordic_busy = cordic_busy;
    assign sts.div_busy    = div_busy;

    // Configuration and vehicle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg       <= RST_MAX_SPEED;
            friction_step_reg   <= RST_FRICTION;
            accel_step_reg      <= RST_ACCEL;
            steer_magnitude_reg <= RST_STEER_MAG;
            wheel_base_reg      <= RST_WHEEL_BASE;
            cell_size_reg       <= RST_CELL_SIZE;
            position_x_reg      <= RST_POSITION;
            position_y_reg      <= RST_POSITION;
            heading_reg         <= RST_HEADING;
            speed_reg           <= '0;
            steer_angle_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_SPEED:       max_speed_reg       <= cfg_data[10:0];
                    REG_FRICTION_STEP:   friction_step_reg   <= cfg_data[7:0];
                    REG_ACCEL_STEP:      accel_step_reg      <= cfg_data[7:0];
                    REG_STEER_MAGNITUDE: steer_magnitude_reg <= cfg_data[13:0];
                    REG_WHEEL_BASE:      wheel_base_reg      <= cfg_data[9:0];
                    REG_CELL_SIZE:       cell_size_reg       <= cfg_data[9:0];
                    default:             ;
                endcase
            end
            if (cmd.speed)
            begin
                speed_reg       <= sp_c[11:0];
                steer_angle_reg <= steer_next;
            end
            if (cmd.add)
            begin
                position_x_reg <= position_x_reg + rnd_x[31:0];
                position_y_reg <= position_y_reg + rnd_y[31:0];
            end
            if (cmd.store_heading)
            begin
                heading_reg <= zero_reg ? '0 : z_rnd[31:TURN_SHIFT];
            end
        end
    end

    // Working and output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg       <= dt;
            throttle_reg <= throttle;
            steer_reg    <= steer;
        end
        if (cmd.distance)
        begin
            d_reg <= d_full[27:0];
        end
        if (cmd.rot_h_go || cmd.rot_f_go)
        begin
            flip_reg <= flip_next;
        end
        if (cmd.store_h)
        begin
            ch_reg <= c_cos;
            sh_reg <= c_sin;
        end
        if (cmd.store_f)
        begin
            cf_reg <= c_cos;
            sf_reg <= c_sin;
        end
        if (cmd.prep)
        begin
            ax_reg <= (ZW+1)'(ch_reg) + (ZW+1)'(cf_reg);
            bx_reg <= (ZW+1)'(cf_reg) - (ZW+1)'(ch_reg);
            ay_reg <= (ZW+1)'(sh_reg) + (ZW+1)'(sf_reg);
            by_reg <= (ZW+1)'(sf_reg) - (ZW+1)'(sh_reg);
        end
        if (cmd.mul)
        begin
            mx_reg <= d_reg * ax_reg;
            nx_reg <= d_reg * bx_reg;
            my_reg <= d_reg * ay_reg;
            ny_reg <= d_reg * by_reg;
            wx_reg <= $signed({1'b0, wheel_base_reg}) * ch_reg;
            wy_reg <= $signed({1'b0, wheel_base_reg}) * sh_reg;
        end
        if (cmd.add)
        begin
            vx_reg <= (CW'(wx_reg) <<< 16) + CW'(nx_reg);
            vy_reg <= (CW'(wy_reg) <<< 16) + CW'(ny_reg);
        end
        if (cmd.vec_go)
        begin
            zero_reg <= (vx_reg == '0) && (vy_reg == '0);
        end
        if (cmd.out_load)
        begin
            pos_x_reg       <= position_x_reg;
            pos_y_reg       <= position_y_reg;
            heading_out_reg <= 16'($signed(heading_reg));
            speed_out_reg   <= speed_reg;
            cell_col_reg    <= div_col;
            cell_row_reg    <= div_row;
        end
    end

    assign pos_x       = $signed(pos_x_reg);
    assign pos_y       = $signed(pos_y_reg);
    assign heading_out = heading_out_reg;
    assign speed_out   = speed_out_reg;
    assign cell_col    = $signed(cell_col_reg);
    assign cell_row    = $signed(cell_row_reg);

endmodule

### src/vehicle_bicycle_model_step_core.sv
// Top level of the vehicle bicycle-model step core: sequencer plus datapath.
// Depends on vbms_pkg, vbms_ctrl and vbms_datapath.
//
// Each accepted transaction (dt, throttle, steer) advances the vehicle pose by
// one tick and returns one result: position, heading, speed and grid cell. The
// core works on one tick at a time; a tick runs three passes on one shared CORDIC
// engine (rotations for heading and for heading plus steer, then vectoring for
// the new heading), the tail of a two-lane divider that starts with the vectoring
// pass and yields one quotient bit per cycle for the cell column and row, and the
// single steps of the sequencer. A finished result sits in an output register,
// so the next tick is accepted while it waits; a second finished result is held
// in the core until the first is taken. Write configuration only while no tick
// is in flight.
module vehicle_bicycle_model_step_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vbms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vbms_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     dt,
    input  logic [1:0]                      throttle,
    input  logic [1:0]                      steer,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              pos_x,
    output logic signed [31:0]              pos_y,
    output logic signed [15:0]              heading_out,
    output logic signed [11:0]              speed_out,
    output logic signed [23:0]              cell_col,
    output logic signed [23:0]              cell_row
);
    import vbms_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    vbms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    vbms_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dt          (dt),
        .throttle    (throttle),
        .steer       (steer),
        .cmd         (cmd),
        .sts         (sts),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading_out (heading_out),
        .speed_out   (speed_out),
        .cell_col    (cell_col),
        .cell_row    (cell_row)
    );

endmodule
